// ----- design/wpdc_pkg.sv -----
// ----------------------------------------------------------------------------
// wpdc_pkg
// Shared types, codes and the microcode table of the windowed PID drive
// controller.
// ----------------------------------------------------------------------------
package wpdc_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_GAIN_P    = 3'd0;
   localparam logic [2:0] CSR_GAIN_I    = 3'd1;
   localparam logic [2:0] CSR_GAIN_D    = 3'd2;
   localparam logic [2:0] CSR_SCALE     = 3'd3;
   localparam logic [2:0] CSR_WINDOW    = 3'd4;
   localparam logic [2:0] CSR_DRIVE_MAX = 3'd5;
   localparam logic [2:0] CSR_DRIVE_MIN = 3'd6;

   // configuration register reset values
   localparam logic signed [15:0] GAIN_P_RST    = 16'sd512;
   localparam logic signed [15:0] GAIN_I_RST    = 16'sd10;
   localparam logic signed [15:0] GAIN_D_RST    = 16'sd0;
   localparam logic [15:0]        SCALE_RST     = 16'd256;
   localparam logic [15:0]        WINDOW_RST    = 16'd50;
   localparam logic signed [7:0]  DRIVE_MAX_RST = 8'sd127;
   localparam logic signed [7:0]  DRIVE_MIN_RST = -8'sd127;

   // datapath widths
   localparam int ErrW  = 33;   // position error, Q.8
   localparam int DerW  = 34;   // error difference
   localparam int SumW  = 48;   // saturating integral
   localparam int MulBW = 35;   // wide multiplier operand
   localparam int ProdW = 51;   // 16 x 35 signed product
   localparam int AccW  = 64;   // PID sum, Q.16
   localparam int HalfW = 24;   // integral split for the multiplier

   typedef struct packed {
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
      logic [15:0]        sensor_scale;
      logic [15:0]        integral_window;
      logic signed [7:0]  drive_max;
      logic signed [7:0]  drive_min;
   } cfg_type;

   // multiplier operand pairs
   localparam logic [2:0] MS_SCALE  = 3'd0;  // encoder count x scale
   localparam logic [2:0] MS_P_ERR  = 3'd1;  // gain_p x error
   localparam logic [2:0] MS_D_DER  = 3'd2;  // gain_d x error difference
   localparam logic [2:0] MS_I_SLO  = 3'd3;  // gain_i x low integral half
   localparam logic [2:0] MS_I_SHI  = 3'd4;  // gain_i x high integral half

   // accumulator operations
   localparam logic [1:0] ACC_HOLD   = 2'd0;
   localparam logic [1:0] ACC_LOAD   = 2'd1;
   localparam logic [1:0] ACC_ADD    = 2'd2;
   localparam logic [1:0] ACC_ADD_HI = 2'd3;  // add product shifted by HalfW

   // program steps
   localparam logic [3:0] STEP_SCALE = 4'd0;
   localparam logic [3:0] STEP_ERR   = 4'd1;
   localparam logic [3:0] STEP_EVAL  = 4'd2;
   localparam logic [3:0] STEP_SUM   = 4'd3;
   localparam logic [3:0] STEP_ACC_D = 4'd4;
   localparam logic [3:0] STEP_ACC_L = 4'd5;
   localparam logic [3:0] STEP_ACC_H = 4'd6;
   localparam logic [3:0] STEP_DRIVE = 4'd7;
   localparam logic [3:0] STEP_CLEAR = 4'd8;

   typedef struct packed {
      logic [2:0] mul_sel;
      logic       mul_en;
      logic [1:0] acc_op;
      logic       err_load;
      logic       eval;      // window test, difference, error history
      logic       sum_upd;
      logic       drive;     // final rounding and clamp
      logic       clear;     // stopped: clear state, zero result
      logic       jmp_off;   // jump to target when the loop is stopped
      logic       last;
      logic [3:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic          active;
      logic          fire;    // last step completes, result register loads
      ctrl_word_type cw;
   } exec_type;

   // microcode table
   function automatic ctrl_word_type wpdc_rom(input logic [3:0] step);
      ctrl_word_type w;
      w = '0;
      unique case (step)
         STEP_SCALE: begin
            w.mul_sel = MS_SCALE;   w.mul_en = 1'b1;
            w.jmp_off = 1'b1;       w.target = STEP_CLEAR;
         end
         STEP_ERR: begin
            w.err_load = 1'b1;
         end
         STEP_EVAL: begin
            w.eval = 1'b1;
            w.mul_sel = MS_P_ERR;   w.mul_en = 1'b1;
         end
         STEP_SUM: begin
            w.sum_upd = 1'b1;       w.acc_op = ACC_LOAD;
            w.mul_sel = MS_D_DER;   w.mul_en = 1'b1;
         end
         STEP_ACC_D: begin
            w.acc_op = ACC_ADD;
            w.mul_sel = MS_I_SLO;   w.mul_en = 1'b1;
         end
         STEP_ACC_L: begin
            w.acc_op = ACC_ADD;
            w.mul_sel = MS_I_SHI;   w.mul_en = 1'b1;
         end
         STEP_ACC_H: begin
            w.acc_op = ACC_ADD_HI;
         end
         STEP_DRIVE: begin
            w.drive = 1'b1;         w.last = 1'b1;
         end
         default: begin
            w.clear = 1'b1;         w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- design/wpdc_ifs.sv -----
// ----------------------------------------------------------------------------
// wpdc channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface wpdc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] encoder_count;
   logic signed [15:0] target_position;
   logic               control_on;

   modport source (output valid, encoder_count, target_position, control_on,
                   input ready);
   modport sink   (input valid, encoder_count, target_position, control_on,
                   output ready);
endinterface

interface wpdc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] left_drive;
   logic signed [7:0] right_drive;

   modport source (output valid, left_drive, right_drive, input ready);
   modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

interface wpdc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [15:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- design/windowed_pid_drive_controller.sv -----
// ----------------------------------------------------------------------------
// windowed_pid_drive_controller
// PID position loop with a windowed, saturating integral; drives one motor
// with the clamped result and the opposite motor with its negation.
//
//   channel   direction  carries
//   req_port  in         encoder_count, target_position, control_on
//   rsp_port  out        left_drive, right_drive
//   csr_port  in         reg_index, wr_data (gains, scale, window, clamps)
//
// A running transaction takes 8 steps of the microcode program, one per
// cycle, set by the single shared 16 x 35 multiplier; a stopped one takes 2.
// One transaction is in flight at a time; the next is taken once the program
// ends, even while the previous response still waits in its register.
// A full response register holds the program on its last step.
// Reset restores the register defaults and clears the error history.
// ----------------------------------------------------------------------------
module windowed_pid_drive_controller (
   input logic        clock,
   input logic        reset,
   wpdc_req_if.sink   req_port,
   wpdc_rsp_if.source rsp_port,
   wpdc_csr_if.sink   csr_port
);

   wpdc_pkg::cfg_type  cfg;
   wpdc_pkg::exec_type exec;
   logic               busy;
   logic               start;
   logic               run_on;
   logic               out_free;

   // request accepted while the program is idle
   assign start = req_port.valid && !busy;

   wpdc_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_port),
      .cfg   (cfg)
   );

   wpdc_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .run_on   (run_on),
      .out_free (out_free),
      .busy     (busy),
      .exec     (exec)
   );

   wpdc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cfg      (cfg),
      .exec     (exec),
      .req      (req_port),
      .rsp      (rsp_port),
      .run_on   (run_on),
      .out_free (out_free)
   );

endmodule

// ----- design/wpdc_csr_regs.sv -----
// ----------------------------------------------------------------------------
// wpdc_csr_regs
// Gain, scale, window and clamp registers written over the csr channel.
// ----------------------------------------------------------------------------
module wpdc_csr_regs (
   input  logic              clock,
   input  logic              reset,
   wpdc_csr_if.sink          csr,
   output wpdc_pkg::cfg_type cfg
);

   wpdc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.reg_index)
            wpdc_pkg::CSR_GAIN_P:    cfg_in.gain_p          = csr.wr_data;
            wpdc_pkg::CSR_GAIN_I:    cfg_in.gain_i          = csr.wr_data;
            wpdc_pkg::CSR_GAIN_D:    cfg_in.gain_d          = csr.wr_data;
            wpdc_pkg::CSR_SCALE:     cfg_in.sensor_scale    = csr.wr_data;
            wpdc_pkg::CSR_WINDOW:    cfg_in.integral_window = csr.wr_data;
            wpdc_pkg::CSR_DRIVE_MAX: cfg_in.drive_max       = csr.wr_data[7:0];
            wpdc_pkg::CSR_DRIVE_MIN: cfg_in.drive_min       = csr.wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= wpdc_pkg::GAIN_P_RST;
         cfg_ff.gain_i          <= wpdc_pkg::GAIN_I_RST;
         cfg_ff.gain_d          <= wpdc_pkg::GAIN_D_RST;
         cfg_ff.sensor_scale    <= wpdc_pkg::SCALE_RST;
         cfg_ff.integral_window <= wpdc_pkg::WINDOW_RST;
         cfg_ff.drive_max       <= wpdc_pkg::DRIVE_MAX_RST;
         cfg_ff.drive_min       <= wpdc_pkg::DRIVE_MIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/wpdc_sequencer.sv -----
// ----------------------------------------------------------------------------
// wpdc_sequencer
// Step counter over the microcode table, with the stopped-loop jump and the
// hold on the last step while the result register is full.
// ----------------------------------------------------------------------------
module wpdc_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               run_on,
   input  logic               out_free,
   output logic               busy,
   output wpdc_pkg::exec_type exec
);

   logic                    busy_ff, busy_in;
   logic [3:0]              step_ff, step_in;
   logic                    fire;
   wpdc_pkg::ctrl_word_type cw;

   assign cw   = wpdc_pkg::wpdc_rom(step_ff);
   assign busy = busy_ff;

   // next step
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      fire    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = wpdc_pkg::STEP_SCALE;
      end else if (busy_ff) begin
         priority if (cw.jmp_off && !run_on) begin
            step_in = cw.target;
         end else if (cw.last) begin
            if (out_free) begin
               busy_in = 1'b0;
               fire    = 1'b1;
            end
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   assign exec.active = busy_ff;
   assign exec.fire   = fire;
   assign exec.cw     = cw;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= wpdc_pkg::STEP_SCALE;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

// ----- design/wpdc_datapath.sv -----
// ----------------------------------------------------------------------------
// wpdc_datapath
// Shared multiplier, accumulator, error history, integral and result
// register, all steered by the current control word.
// ----------------------------------------------------------------------------
module wpdc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  wpdc_pkg::cfg_type  cfg,
   input  wpdc_pkg::exec_type exec,
   wpdc_req_if.sink           req,
   wpdc_rsp_if.source         rsp,
   output logic               run_on,
   output logic               out_free
);

   localparam int ErrW  = wpdc_pkg::ErrW;
   localparam int DerW  = wpdc_pkg::DerW;
   localparam int SumW  = wpdc_pkg::SumW;
   localparam int MulBW = wpdc_pkg::MulBW;
   localparam int ProdW = wpdc_pkg::ProdW;
   localparam int AccW  = wpdc_pkg::AccW;
   localparam int HalfW = wpdc_pkg::HalfW;

   // captured transaction
   logic signed [15:0]      count_ff, target_ff;
   logic                    on_ff;
   // working registers
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic signed [ErrW-1:0]  err_ff, prev_ff;
   logic signed [DerW-1:0]  der_ff;
   logic signed [SumW-1:0]  sum_ff, sum_in;
   logic                    inwin_ff;
   // result register
   logic                    valid_ff, valid_in;
   logic signed [7:0]       left_ff, right_ff, left_in, right_in;

   logic signed [15:0]      mul_a;
   logic signed [MulBW-1:0] mul_b;
   logic signed [ErrW:0]    err_wide;
   logic [ErrW:0]           err_abs;
   logic signed [SumW:0]    sum_wide;
   logic signed [AccW-1:0]  prod_ext;
   logic signed [AccW-1:0]  acc_bias;
   logic signed [47:0]      quot;
   logic signed [7:0]       drive;

   wpdc_pkg::ctrl_word_type cw;
   assign cw = exec.cw;

   assign run_on   = on_ff;
   assign out_free = !valid_ff || rsp.ready;

   // multiplier operand select
   always_comb begin
      unique case (cw.mul_sel)
         wpdc_pkg::MS_SCALE: begin
            mul_a = count_ff;
            mul_b = $signed({{(MulBW-16){1'b0}}, cfg.sensor_scale});
         end
         wpdc_pkg::MS_P_ERR: begin
            mul_a = cfg.gain_p;
            mul_b = $signed({{(MulBW-ErrW){err_ff[ErrW-1]}}, err_ff});
         end
         wpdc_pkg::MS_D_DER: begin
            mul_a = cfg.gain_d;
            mul_b = $signed({{(MulBW-DerW){der_ff[DerW-1]}}, der_ff});
         end
         wpdc_pkg::MS_I_SLO: begin
            mul_a = cfg.gain_i;
            mul_b = $signed({{(MulBW-HalfW){1'b0}}, sum_ff[HalfW-1:0]});
         end
         wpdc_pkg::MS_I_SHI: begin
            mul_a = cfg.gain_i;
            mul_b = $signed({{(MulBW-(SumW-HalfW)){sum_ff[SumW-1]}},
                             sum_ff[SumW-1:HalfW]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // one shared signed multiplier, registered product
   always_comb begin
      prod_in = prod_ff;
      if (exec.active && cw.mul_en) begin
         prod_in = ProdW'(mul_a) * ProdW'(mul_b);
      end
   end

   // accumulator of the three terms
   always_comb begin
      prod_ext = AccW'(prod_ff);
      unique case (cw.acc_op)
         wpdc_pkg::ACC_HOLD:   acc_in = acc_ff;
         wpdc_pkg::ACC_LOAD:   acc_in = prod_ext;
         wpdc_pkg::ACC_ADD:    acc_in = acc_ff + prod_ext;
         wpdc_pkg::ACC_ADD_HI: acc_in = acc_ff + (prod_ext <<< HalfW);
         default:              acc_in = acc_ff;
      endcase
      if (!exec.active) begin
         acc_in = acc_ff;
      end
   end

   // error, its magnitude and the saturating integral
   always_comb begin
      err_wide = $signed(prod_ff[ErrW:0])
               - $signed({{(ErrW-23){target_ff[15]}}, target_ff, 8'b0});
      err_abs  = err_ff[ErrW-1] ? (ErrW+1)'(-$signed({err_ff[ErrW-1], err_ff}))
                                : (ErrW+1)'({1'b0, err_ff});
      sum_wide = $signed({sum_ff[SumW-1], sum_ff})
               + $signed({{(SumW+1-ErrW){err_ff[ErrW-1]}}, err_ff});
      priority if (!inwin_ff) begin
         sum_in = '0;
      end else if (sum_wide[SumW] != sum_wide[SumW-1]) begin
         sum_in = {sum_wide[SumW], {(SumW-1){!sum_wide[SumW]}}};
      end else begin
         sum_in = sum_wide[SumW-1:0];
      end
   end

   // round toward zero by 2^16, then clamp high before low
   always_comb begin
      acc_bias = acc_ff + (acc_ff[AccW-1] ? AccW'(16'hFFFF) : AccW'(0));
      quot     = acc_bias[AccW-1:16];
      drive    = 8'(quot);
      priority if (quot > 48'(cfg.drive_max)) begin
         drive = cfg.drive_max;
      end else if (quot < 48'(cfg.drive_min)) begin
         drive = cfg.drive_min;
      end else begin
         drive = quot[7:0];
      end
      if (drive > 48'(cfg.drive_max)) begin
         drive = cfg.drive_max;
      end
      if (drive < cfg.drive_min) begin
         drive = cfg.drive_min;
      end
   end

   // result register, loads as the last step completes
   always_comb begin
      valid_in = valid_ff && !rsp.ready;
      left_in  = left_ff;
      right_in = right_ff;
      if (exec.fire) begin
         valid_in = 1'b1;
         if (cw.clear) begin
            left_in  = '0;
            right_in = '0;
         end else begin
            left_in  = drive;
            right_in = (drive == -8'sd128) ? 8'sd127 : 8'(-drive);
         end
      end
   end

   assign req.ready       = 1'b0 || !exec.active;
   assign rsp.valid       = valid_ff;
   assign rsp.left_drive  = left_ff;
   assign rsp.right_drive = right_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         on_ff    <= 1'b0;
         inwin_ff <= 1'b0;
         prev_ff  <= '0;
         sum_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (start) begin
            on_ff <= req.control_on;
         end
         if (exec.active && cw.eval) begin
            inwin_ff <= (cfg.gain_i != 16'sd0)
                     && (err_abs < (ErrW+1)'({cfg.integral_window, 8'b0}));
            prev_ff  <= err_ff;
         end
         if (exec.active && cw.sum_upd) begin
            sum_ff <= sum_in;
         end
         if (exec.fire && cw.clear) begin
            prev_ff <= '0;
            sum_ff  <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      if (start) begin
         count_ff  <= req.encoder_count;
         target_ff <= req.target_position;
      end
      if (exec.active && cw.err_load) begin
         err_ff <= err_wide[ErrW-1:0];
      end
      if (exec.active && cw.eval) begin
         der_ff <= $signed({err_ff[ErrW-1], err_ff}) - $signed({prev_ff[ErrW-1], prev_ff});
      end
   end

endmodule

// ----- test/tb_windowed_pid_drive_controller.sv -----
// ----------------------------------------------------------------------------
// tb_windowed_pid_drive_controller
// Self-checking bench for the windowed PID drive controller. A cycle-free
// model of the control law predicts both motor drives for every accepted
// tick, and a monitor compares each response in order. Directed ticks cover
// register extremes, the window, the clamps and the stopped path. Random
// control bursts then run under several register settings, with idle cycles
// and backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_windowed_pid_drive_controller;

   // index with no register behind it
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   // integral saturation bounds
   localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint INTEG_MIN = -INTEG_MAX - 1;

   typedef struct packed {
      logic signed [7:0] left_drive;
      logic signed [7:0] right_drive;
   } drive_pair_type;

   logic clock = 1'b0;
   logic reset;

   wpdc_req_if req_if ();
   wpdc_rsp_if rsp_if ();
   wpdc_csr_if csr_if ();

   windowed_pid_drive_controller uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // register shadow and loop state of the model
   wpdc_pkg::cfg_type ctrl_cfg;
   longint            last_pos_err;
   longint            err_integral;
   drive_pair_type    pending_drives[$];

   bit calm = 1'b0;
   int mismatches = 0;
   int running_ticks = 0;
   int stopped_ticks = 0;
   int reg_writes = 0;
   int drives_checked = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run ends here if the design hangs
   initial begin
      #5_000_000;
      $display("windowed_pid_drive_controller verification failed");
      $finish;
   end

   // control law for one tick; updates the loop state
   function automatic drive_pair_type predict_drive(input logic signed [15:0] cnt,
                                                    input logic signed [15:0] tgt,
                                                    input logic on);
      longint pos_err, mag, diff, acc, drv, neg, total;
      drive_pair_type r;
      r = '0;
      if (!on) begin
         last_pos_err = 0;
         err_integral = 0;
         return r;
      end
      pos_err = longint'(cnt) * longint'(ctrl_cfg.sensor_scale) - longint'(tgt) * 256;
      mag = (pos_err < 0) ? -pos_err : pos_err;
      // integrate only inside the window, with the integral gain enabled
      if (ctrl_cfg.gain_i != 0 && mag < longint'(ctrl_cfg.integral_window) * 256) begin
         total = err_integral + pos_err;
         if (total > INTEG_MAX) total = INTEG_MAX;
         if (total < INTEG_MIN) total = INTEG_MIN;
         err_integral = total;
      end else begin
         err_integral = 0;
      end
      diff = pos_err - last_pos_err;
      last_pos_err = pos_err;
      acc = longint'($signed(ctrl_cfg.gain_p)) * pos_err
          + longint'($signed(ctrl_cfg.gain_i)) * err_integral
          + longint'($signed(ctrl_cfg.gain_d)) * diff;
      // q.16 to integer, toward zero
      drv = acc / 64'sd65536;
      if (drv > longint'($signed(ctrl_cfg.drive_max))) drv = longint'($signed(ctrl_cfg.drive_max));
      if (drv < longint'($signed(ctrl_cfg.drive_min))) drv = longint'($signed(ctrl_cfg.drive_min));
      neg = -drv;
      if (neg > 127) neg = 127;
      r.left_drive = drv[7:0];
      r.right_drive = neg[7:0];
      return r;
   endfunction

   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
   endtask

   // one tick transaction on the request channel
   task automatic send_tick(input logic signed [15:0] cnt, input logic signed [15:0] tgt,
                            input logic on);
      while (!calm && $urandom_range(0, 99) < 35) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.encoder_count <= cnt;
      req_if.target_position <= tgt;
      req_if.control_on <= on;
      do @(posedge clock); while (!req_if.ready);
      pending_drives.push_back(predict_drive(cnt, tgt, on));
      if (on) running_ticks++;
      else stopped_ticks++;
   endtask

   // hold the sender until every response is back
   task automatic drain;
      req_if.valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
   endtask

   // register write transaction; valid stays up for back-to-back writes
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_if.valid <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wr_data <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         wpdc_pkg::CSR_GAIN_P:    ctrl_cfg.gain_p = data;
         wpdc_pkg::CSR_GAIN_I:    ctrl_cfg.gain_i = data;
         wpdc_pkg::CSR_GAIN_D:    ctrl_cfg.gain_d = data;
         wpdc_pkg::CSR_SCALE:     ctrl_cfg.sensor_scale = data;
         wpdc_pkg::CSR_WINDOW:    ctrl_cfg.integral_window = data;
         wpdc_pkg::CSR_DRIVE_MAX: ctrl_cfg.drive_max = data[7:0];
         wpdc_pkg::CSR_DRIVE_MIN: ctrl_cfg.drive_min = data[7:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic program_regs(input int gp, input int gi, input int gd, input int sc,
                               input int win, input int hi, input int lo);
      drain();
      write_reg(wpdc_pkg::CSR_GAIN_P, 16'(gp));
      write_reg(wpdc_pkg::CSR_GAIN_I, 16'(gi));
      write_reg(wpdc_pkg::CSR_GAIN_D, 16'(gd));
      write_reg(wpdc_pkg::CSR_SCALE, 16'(sc));
      write_reg(wpdc_pkg::CSR_WINDOW, 16'(win));
      write_reg(wpdc_pkg::CSR_DRIVE_MAX, 16'(hi));
      write_reg(wpdc_pkg::CSR_DRIVE_MIN, 16'(lo));
      csr_if.valid <= 1'b0;
   endtask

   // either moderate loop tuning or anything the registers hold
   task automatic random_config(input bit wide);
      int gp, gi, gd, sc, win, hi, lo;
      if (wide) begin
         gp = $urandom;
         gi = $urandom;
         gd = $urandom;
         sc = $urandom;
         win = $urandom;
         hi = $urandom_range(0, 255);
         lo = $urandom_range(0, 255);
      end else begin
         gp = int'($urandom_range(0, 2048)) - 1024;
         gi = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(0, 128)) - 64;
         gd = int'($urandom_range(0, 1024)) - 512;
         sc = ($urandom_range(0, 1) == 0) ? 256 : int'($urandom_range(64, 1024));
         win = $urandom_range(0, 400);
         hi = $urandom_range(0, 127);
         lo = -int'($urandom_range(0, 128));
      end
      program_regs(gp, gi, gd, sc, win, hi, lo);
   endtask

   // shaft wandering around a fixed target, with stops and noise mixed in
   task automatic control_burst(input int len);
      int c, w, pick;
      logic signed [15:0] tgt;
      c = int'($urandom_range(0, 2000)) - 1000;
      w = (ctrl_cfg.integral_window > 2000) ? 2000 : int'(ctrl_cfg.integral_window);
      tgt = clip16(longint'(c) * longint'(ctrl_cfg.sensor_scale) / 256
                   + longint'($urandom_range(0, 2 * w)) - w);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_tick(16'($urandom), 16'($urandom), 1'b0);
         end else if (pick < 12) begin
            send_tick(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
         end else begin
            send_tick(clip16(c), tgt, 1'b1);
         end
         c = int'(clip16(c + int'($urandom_range(0, 8)) - 4));
      end
   endtask

   // response monitor and receiver backpressure
   always @(posedge clock) begin : check_rsp
      drive_pair_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            drives_checked++;
            if (pending_drives.size() == 0) begin
               flag_mismatch($sformatf("response with nothing pending: left %0d right %0d",
                                       rsp_if.left_drive, rsp_if.right_drive));
            end else begin
               want = pending_drives.pop_front();
               if (rsp_if.left_drive !== want.left_drive)
                  flag_mismatch($sformatf("left_drive expected %0d, got %0d",
                                          want.left_drive, rsp_if.left_drive));
               if (rsp_if.right_drive !== want.right_drive)
                  flag_mismatch($sformatf("right_drive expected %0d, got %0d",
                                          want.right_drive, rsp_if.right_drive));
            end
         end
         rsp_if.ready <= calm || ($urandom_range(0, 99) >= 35);
      end
   end

   // default registers: window, integral build-up, clamps, stop and restart
   task automatic test_default_loop;
      send_tick(16'sd0, 16'sd0, 1'b0);
      send_tick(16'sd0, 16'sd0, 1'b1);
      send_tick(16'sd10, 16'sd0, 1'b1);
      send_tick(16'sd10, 16'sd0, 1'b1);
      send_tick(-16'sd20, 16'sd0, 1'b1);
      drain();
      send_tick(16'sd100, 16'sd0, 1'b1);
      send_tick(-16'sd100, 16'sd0, 1'b1);
      send_tick(16'sh7FFF, 16'sh8000, 1'b1);
      send_tick(16'sh8000, 16'sh7FFF, 1'b1);
      send_tick(16'sd3, 16'sd0, 1'b0);
      send_tick(16'sd3, 16'sd0, 1'b1);
   endtask

   // gains, scale, window and clamps at their limits
   task automatic test_register_extremes;
      // integral off, full scale, lowest clamp so the negation saturates
      program_regs(-32768, 0, 32767, 65535, 65535, 127, -128);
      send_tick(16'sd1, 16'sd0, 1'b1);
      send_tick(16'sh8000, 16'sh7FFF, 1'b1);
      send_tick(16'sh7FFF, 16'sh8000, 1'b1);
      send_tick(16'sh7FFF, 16'sh8000, 1'b1);
      // zero scale and window, crossed clamps: drive_min wins
      program_regs(32767, -32768, -32768, 0, 0, -50, 50);
      send_tick(16'sd5, 16'sd3, 1'b1);
      send_tick(16'sh8000, 16'sh8000, 1'b1);
      send_tick(16'sd0, 16'sh7FFF, 1'b1);
      // wide window with strong integral gain
      program_regs(0, 32767, 0, 256, 65535, -128, -128);
      send_tick(16'sd200, 16'sd0, 1'b1);
      send_tick(16'sd200, 16'sd0, 1'b1);
      // write to an index with no register is dropped
      program_regs(wpdc_pkg::GAIN_P_RST, wpdc_pkg::GAIN_I_RST, wpdc_pkg::GAIN_D_RST,
                   wpdc_pkg::SCALE_RST, wpdc_pkg::WINDOW_RST,
                   wpdc_pkg::DRIVE_MAX_RST, wpdc_pkg::DRIVE_MIN_RST);
      write_reg(CSR_UNUSED, 16'hFFFF);
      csr_if.valid <= 1'b0;
      send_tick(16'sd10, 16'sd0, 1'b1);
      send_tick(16'sd12, 16'sd0, 1'b1);
   endtask

   // random bursts under changing register settings
   task automatic test_random_traffic;
      int budget, len;
      for (int ph = 0; ph < 10; ph++) begin
         random_config(ph % 3 == 2);
         calm = (ph == 4);
         budget = calm ? 160 : 110;
         while (budget > 0) begin
            len = $urandom_range(4, 24);
            if (len > budget) len = budget;
            control_burst(len);
            budget -= len;
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      ctrl_cfg = '{gain_p: wpdc_pkg::GAIN_P_RST, gain_i: wpdc_pkg::GAIN_I_RST,
                   gain_d: wpdc_pkg::GAIN_D_RST, sensor_scale: wpdc_pkg::SCALE_RST,
                   integral_window: wpdc_pkg::WINDOW_RST,
                   drive_max: wpdc_pkg::DRIVE_MAX_RST,
                   drive_min: wpdc_pkg::DRIVE_MIN_RST};
      last_pos_err = 0;
      err_integral = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.encoder_count = '0;
      req_if.target_position = '0;
      req_if.control_on = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.reg_index = '0;
      csr_if.wr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_default_loop();
      test_register_extremes();
      test_random_traffic();

      // let the last responses out, then watch for strays
      drain();
      repeat (20) @(posedge clock);

      $display("ran %0d control ticks (%0d stopped) over %0d register writes",
               running_ticks + stopped_ticks, stopped_ticks, reg_writes);
      $display("checked %0d drive responses, %0d mismatches", drives_checked, mismatches);
      if (mismatches == 0) begin
         $display("windowed_pid_drive_controller verification clean");
      end else begin
         $display("windowed_pid_drive_controller verification failed");
      end
      $finish;
   end

endmodule
